@@ hw/rtl/npsh_pkg.sv @@
// Shared types, constants and a helper function of the nearest point session histogram.
package npsh_pkg;

  localparam int CountWidthDef = 16;
  localparam int FracBitsDef   = 8;
  localparam int NUM_REFS      = 8;
  localparam int RefIdxW       = $clog2(NUM_REFS);
  localparam int RefCntW       = RefIdxW + 1;
  localparam int CoordW        = 16;
  localparam int BinW          = 4;
  localparam int OutCountW     = 16;
  localparam int DiffW         = CoordW + 1;
  localparam int SqW           = 2 * DiffW;
  localparam int DistW         = SqW + 1;

  // Reference points in tenths of a metre, index 0 to 7 for bins 1 to 8.
  localparam int RefTenthsX [NUM_REFS] = '{30, 50, 64, 70, 70, 64, 50, 30};
  localparam int RefTenthsY [NUM_REFS] = '{64, 50, 30, 10, -10, -30, -50, -64};

  typedef enum logic [1:0] {
    KIND_POS  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_JOY  = 2'd2
  } npsh_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_REPORT
  } npsh_state_e;

  typedef struct packed {
    logic load_pos;
    logic set_buttons;
    logic srch_start;
    logic srch_step;
    logic update;
    logic rep_emit;
  } npsh_cmd_t;

  typedef struct packed {
    logic recording;
    logic total_nz;
    logic srch_done;
    logic rep_last;
    logic out_free;
  } npsh_status_t;

  // Converts tenths of a metre to fixed point, rounding halves away from zero.
  function automatic int tenths_to_fixed(input int tenths, input int frac);
    int mag;
    mag = (tenths < 0) ? -tenths : tenths;
    mag = (mag * (1 << frac) + 5) / 10;
    return (tenths < 0) ? -mag : mag;
  endfunction

endpackage

@@ hw/rtl/npsh_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface npsh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        start_button;
  logic        stop_button;

  modport source (output valid, kind, pos_x, pos_y, start_button, stop_button, input ready);
  modport sink (input valid, kind, pos_x, pos_y, start_button, stop_button, output ready);
endinterface

interface npsh_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  bin_number;
  logic [15:0] bin_count;
  logic [15:0] sample_total;
  logic [3:0]  final_bin;
  logic        last_of_run;

  modport source (output valid, bin_number, bin_count, sample_total, final_bin, last_of_run,
                  input ready);
  modport sink (input valid, bin_number, bin_count, sample_total, final_bin, last_of_run,
                output ready);
endinterface

@@ hw/rtl/npsh_ctrl.sv @@
// Controller state machine that sequences position, button, search and report transactions.
module npsh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_kind_i,
  input  npsh_pkg::npsh_status_t status_i,
  output logic                  in_ready_o,
  output npsh_pkg::npsh_cmd_t   cmd_o
);
  import npsh_pkg::*;

  npsh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (npsh_kind_e'(in_kind_i))
            KIND_POS: cmd_o.load_pos = 1'b1;
            KIND_JOY: cmd_o.set_buttons = 1'b1;
            KIND_TICK: begin
              if (status_i.recording) begin
                cmd_o.srch_start = 1'b1;
                state_d          = ST_SEARCH;
              end else if (status_i.total_nz) begin
                state_d = ST_REPORT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        cmd_o.srch_step = 1'b1;
        if (status_i.srch_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_REPORT: begin
        if (status_i.out_free) begin
          cmd_o.rep_emit = 1'b1;
          if (status_i.rep_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_search_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && status_i.srch_done) |=> state_q == ST_UPDATE)
    else $error("Search did not end in a counter update.");

  a_update_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE |=> state_q == ST_IDLE)
    else $error("Counter update lasted more than one cycle.");

  a_report_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rep_emit && status_i.rep_last) |=> state_q == ST_IDLE)
    else $error("Report did not end after its eighth result.");

  a_report_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPORT || state_q == ST_SEARCH) |-> !in_ready_o)
    else $error("Input accepted while a search or report is in progress.");
`endif

endmodule

@@ hw/rtl/npsh_dp.sv @@
// Datapath with held position, distance unit, saturating counters and result register.
module npsh_dp #(
  parameter int COUNT_WIDTH = npsh_pkg::CountWidthDef,
  parameter int FRAC_BITS   = npsh_pkg::FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  npsh_pkg::npsh_cmd_t    cmd_i,
  output npsh_pkg::npsh_status_t status_o,
  npsh_in_if.sink                in_i,
  npsh_out_if.source             out_o
);
  import npsh_pkg::*;

  logic signed [CoordW-1:0] ref_x [NUM_REFS];
  logic signed [CoordW-1:0] ref_y [NUM_REFS];

  for (genvar g = 0; g < NUM_REFS; g++) begin : g_refs
    assign ref_x[g] = CoordW'(tenths_to_fixed(RefTenthsX[g], FRAC_BITS));
    assign ref_y[g] = CoordW'(tenths_to_fixed(RefTenthsY[g], FRAC_BITS));
  end

  logic signed [CoordW-1:0] held_x_q, held_y_q;
  logic                     recording_q;
  logic [COUNT_WIDTH-1:0]   counts_q [NUM_REFS];
  logic [COUNT_WIDTH-1:0]   total_q;
  logic [BinW-1:0]          latest_q;
  logic [RefCntW-1:0]       srch_cnt_q;
  logic [DistW-1:0]         dist_q, best_dist_q;
  logic [RefIdxW-1:0]       dist_idx_q, best_q;
  logic                     dist_vld_q;
  logic [RefIdxW-1:0]       rep_q;

  logic [COUNT_WIDTH-1:0]   cnt_max;
  logic [RefIdxW-1:0]       srch_idx;
  logic signed [DiffW-1:0]  dx, dy;
  logic signed [SqW-1:0]    sqx, sqy;
  logic [DistW-1:0]         dist_d;
  logic [RefIdxW-1:0]       cnt_addr;
  logic [COUNT_WIDTH-1:0]   cnt_rd;
  logic [COUNT_WIDTH+OutCountW-1:0] cnt_ext, total_ext;

  logic                     out_valid_q;
  logic [BinW-1:0]          out_bin_q, out_final_q;
  logic [OutCountW-1:0]     out_count_q, out_total_q;
  logic                     out_last_q;

  assign cnt_max  = '1;
  assign srch_idx = srch_cnt_q[RefIdxW-1:0];

  // Squared distance from the held position to the reference point under search.
  always_comb begin
    dx     = DiffW'(held_x_q) - DiffW'(ref_x[srch_idx]);
    dy     = DiffW'(held_y_q) - DiffW'(ref_y[srch_idx]);
    sqx    = dx * dx;
    sqy    = dy * dy;
    dist_d = DistW'(unsigned'(sqx)) + DistW'(unsigned'(sqy));
  end

  assign cnt_addr  = cmd_i.update ? best_q : rep_q;
  assign cnt_rd    = counts_q[cnt_addr];
  assign cnt_ext   = {{OutCountW{1'b0}}, cnt_rd};
  assign total_ext = {{OutCountW{1'b0}}, total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q    <= '0;
      held_y_q    <= '0;
      recording_q <= 1'b0;
      total_q     <= '0;
      latest_q    <= BinW'(1);
      srch_cnt_q  <= '0;
      dist_vld_q  <= 1'b0;
      rep_q       <= '0;
      for (int i = 0; i < NUM_REFS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load_pos) begin
        held_x_q <= in_i.pos_x;
        held_y_q <= in_i.pos_y;
      end
      if (cmd_i.set_buttons) begin
        if (in_i.stop_button) begin
          recording_q <= 1'b0;
        end else if (in_i.start_button) begin
          recording_q <= 1'b1;
        end
      end
      if (cmd_i.srch_start) begin
        srch_cnt_q <= '0;
        dist_vld_q <= 1'b0;
      end else if (cmd_i.srch_step) begin
        if (status_o.srch_done) begin
          dist_vld_q <= 1'b0;
        end else begin
          srch_cnt_q <= srch_cnt_q + RefCntW'(1);
          dist_vld_q <= 1'b1;
        end
      end
      if (cmd_i.update) begin
        counts_q[cnt_addr] <= (cnt_rd == cnt_max) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);
        total_q            <= (total_q == cnt_max) ? total_q : total_q + COUNT_WIDTH'(1);
        latest_q           <= BinW'(best_q) + BinW'(1);
      end
      if (cmd_i.rep_emit) begin
        counts_q[cnt_addr] <= '0;
        rep_q              <= rep_q + RefIdxW'(1);
        if (status_o.rep_last) begin
          total_q <= '0;
        end
      end
    end
  end

  // Distance register and running minimum; the earlier index keeps a tie.
  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_step && !status_o.srch_done) begin
      dist_q     <= dist_d;
      dist_idx_q <= srch_idx;
    end
    if (cmd_i.srch_step && dist_vld_q) begin
      if (dist_idx_q == '0 || dist_q < best_dist_q) begin
        best_dist_q <= dist_q;
        best_q      <= dist_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rep_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rep_emit) begin
      out_bin_q   <= BinW'(rep_q) + BinW'(1);
      out_count_q <= cnt_ext[OutCountW-1:0];
      out_total_q <= total_ext[OutCountW-1:0];
      out_final_q <= latest_q;
      out_last_q  <= status_o.rep_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bin_number   = out_bin_q;
  assign out_o.bin_count    = out_count_q;
  assign out_o.sample_total = out_total_q;
  assign out_o.final_bin    = out_final_q;
  assign out_o.last_of_run  = out_last_q;

  assign status_o.recording = recording_q;
  assign status_o.total_nz  = (total_q != '0);
  assign status_o.srch_done = (srch_cnt_q == RefCntW'(NUM_REFS));
  assign status_o.rep_last  = (rep_q == RefIdxW'(NUM_REFS - 1));
  assign status_o.out_free  = !out_valid_q || out_o.ready;

`ifndef SYNTHESIS
  a_total_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rep_emit && status_o.rep_last) |=> (total_q == '0 && rep_q == '0))
    else $error("Session total or report index not cleared after a report.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rep_emit |-> (!out_valid_q || out_o.ready))
    else $error("Result register overwritten before its transaction completed.");

  a_latest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (latest_q != '0 && latest_q <= BinW'(NUM_REFS)))
    else $error("Latest bin outside the reference range.");
`endif

endmodule

@@ hw/rtl/nearest_point_session_histogram_unit.sv @@
// Top level of the nearest point session histogram: controller plus datapath.
// Position, button and idle tick transactions end in the idle state; a recorded tick runs
// the squared-distance search over the eight points and then the counter update.
// A report tick blocks input until its eighth result; the results follow one per cycle
// while the sink is ready, the first valid after the report state loads the result register.
// Asynchronous active-low reset clears counters and position, stops recording, final bin one.
module nearest_point_session_histogram_unit #(
  parameter int COUNT_WIDTH = npsh_pkg::CountWidthDef,
  parameter int FRAC_BITS   = npsh_pkg::FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  npsh_in_if.sink    in_i,
  npsh_out_if.source out_o
);
  import npsh_pkg::*;

  npsh_cmd_t    cmd;
  npsh_status_t status;

  npsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  npsh_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule
